// ===== src/svfm_pkg.sv =====
package svfm_pkg;

   // Mode codes, shared by the state machine and the checker
   localparam logic [2:0] MODE_OK         = 3'd0;
   localparam logic [2:0] MODE_LOW_PEND   = 3'd1;
   localparam logic [2:0] MODE_HIGH_PEND  = 3'd2;
   localparam logic [2:0] MODE_LOW_FAULT  = 3'd3;
   localparam logic [2:0] MODE_HIGH_FAULT = 3'd4;
   localparam logic [2:0] MODE_RECOVER    = 3'd5;

   // Relay request codes
   localparam logic [1:0] RELAY_NONE  = 2'd0;
   localparam logic [1:0] RELAY_OPEN  = 2'd1;
   localparam logic [1:0] RELAY_CLOSE = 2'd2;

   // Band classification
   typedef enum logic [1:0] {
      CLS_IN   = 2'd0,
      CLS_LOW  = 2'd1,
      CLS_HIGH = 2'd2
   } cls_type;

   // Register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWER_LIMIT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPPER_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HYSTERESIS      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONFIRM_PERIODS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECOVER_PERIODS = 3'd4;

   localparam int HYST_BITS = 12;

   // Reset values of the registers
   localparam int LOWER_LIMIT_RST     = 1760;
   localparam int UPPER_LIMIT_RST     = 2640;
   localparam int HYSTERESIS_RST      = 100;
   localparam int CONFIRM_PERIODS_RST = 10;
   localparam int RECOVER_PERIODS_RST = 10;

   // One result beat as produced by the state machine
   typedef struct packed {
      logic [2:0] mode;
      logic       voltage_ok;
      logic       alarm_low;
      logic       alarm_high;
      logic [1:0] relay_cmd;
   } result_type;

endpackage

// ===== src/svfm_classify.sv =====
module svfm_classify
   import svfm_pkg::*;
#(
   parameter int BAND_BITS = 18
) (
   input  logic signed [BAND_BITS-1:0] sample,
   input  logic signed [BAND_BITS-1:0] band_lo,
   input  logic signed [BAND_BITS-1:0] band_hi,
   output cls_type                     cls
);

   // Inside wins; above the upper edge is high, anything else low
   always_comb begin
      if (sample >= band_lo && sample <= band_hi) begin
         cls = CLS_IN;
      end else if (sample > band_hi) begin
         cls = CLS_HIGH;
      end else begin
         cls = CLS_LOW;
      end
   end

endmodule

// ===== src/svfm_fsm.sv =====
module svfm_fsm
   import svfm_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  charging,
   input  cls_type               wide_cls,
   input  cls_type               narrow_cls,
   input  logic [TIMER_BITS-1:0] confirm_periods,
   input  logic [TIMER_BITS-1:0] recover_periods,
   output result_type            result
);

   logic [2:0]            mode_ff,       mode_in;
   logic [TIMER_BITS-1:0] elapsed_ff,    elapsed_in;
   logic                  ok_ff,         ok_in;
   logic                  alarm_low_ff,  alarm_low_in;
   logic                  alarm_high_ff, alarm_high_in;
   logic [1:0]            relay;
   logic [TIMER_BITS-1:0] tick;

   // Saturating period count
   assign tick = (elapsed_ff == {TIMER_BITS{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;

   // Next state for the sample at hand
   always_comb begin
      mode_in       = mode_ff;
      elapsed_in    = elapsed_ff;
      ok_in         = ok_ff;
      alarm_low_in  = alarm_low_ff;
      alarm_high_in = alarm_high_ff;
      relay         = RELAY_NONE;
      case (mode_ff)
         MODE_LOW_PEND, MODE_HIGH_PEND: begin
            if (tick >= confirm_periods) begin
               elapsed_in = tick;
               ok_in      = 1'b0;
               if (charging) begin
                  relay = RELAY_OPEN;
               end
               mode_in = (mode_ff == MODE_LOW_PEND) ? MODE_LOW_FAULT : MODE_HIGH_FAULT;
            end else if (wide_cls == CLS_IN) begin
               elapsed_in = '0;
               mode_in    = MODE_OK;
            end else if (wide_cls == CLS_LOW && mode_ff == MODE_HIGH_PEND) begin
               elapsed_in = '0;
               mode_in    = MODE_LOW_PEND;
            end else if (wide_cls == CLS_HIGH && mode_ff == MODE_LOW_PEND) begin
               elapsed_in = '0;
               mode_in    = MODE_HIGH_PEND;
            end else begin
               elapsed_in = tick;
            end
         end
         MODE_LOW_FAULT, MODE_HIGH_FAULT: begin
            if (narrow_cls == CLS_IN) begin
               elapsed_in = '0;
               mode_in    = MODE_RECOVER;
            end else if (narrow_cls == CLS_LOW) begin
               alarm_low_in  = 1'b1;
               alarm_high_in = 1'b0;
            end else begin
               alarm_high_in = 1'b1;
               alarm_low_in  = 1'b0;
            end
         end
         MODE_RECOVER: begin
            elapsed_in = tick;
            if (tick >= recover_periods) begin
               ok_in = 1'b1;
               if (charging) begin
                  relay = RELAY_CLOSE;
               end
               mode_in = MODE_OK;
            end else if (narrow_cls == CLS_LOW) begin
               mode_in = MODE_LOW_FAULT;
            end else if (narrow_cls == CLS_HIGH) begin
               mode_in = MODE_HIGH_FAULT;
            end
         end
         default: begin
            // Ok, and any code that cannot arise
            alarm_low_in  = 1'b0;
            alarm_high_in = 1'b0;
            mode_in       = MODE_OK;
            if (wide_cls == CLS_IN) begin
               ok_in = 1'b1;
            end else begin
               elapsed_in = '0;
               mode_in    = (wide_cls == CLS_LOW) ? MODE_LOW_PEND : MODE_HIGH_PEND;
            end
         end
      endcase
   end

   // Commit the state when a sample moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OK;
         elapsed_ff    <= '0;
         ok_ff         <= 1'b0;
         alarm_low_ff  <= 1'b0;
         alarm_high_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         elapsed_ff    <= elapsed_in;
         ok_ff         <= ok_in;
         alarm_low_ff  <= alarm_low_in;
         alarm_high_ff <= alarm_high_in;
      end
   end

   assign result.mode       = mode_in;
   assign result.voltage_ok = ok_in;
   assign result.alarm_low  = alarm_low_in;
   assign result.alarm_high = alarm_high_in;
   assign result.relay_cmd  = relay;

endmodule

// ===== src/supply_voltage_fault_monitor.sv =====
// Path: an accepted sample moves through the input register and then the result register,
// where it is offered as a result beat.
// Throughput: one sample per cycle; the result register frees as its beat is taken,
// so the input side stalls only while a result is held and the input register is full.
// Reset: synchronous, active high; empties both stages, returns the monitor to ok
// with flags and alarms clear and loads the register reset values.
module supply_voltage_fault_monitor
   import svfm_pkg::*;
#(
   parameter int VOLT_BITS  = 16,
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VOLT_BITS-1:0]  req_voltage,
   input  logic                  req_charging,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_mode,
   output logic                  rsp_voltage_ok,
   output logic                  rsp_alarm_low,
   output logic                  rsp_alarm_high,
   output logic [1:0]            rsp_relay_cmd,
   input  logic                  csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((VOLT_BITS > TIMER_BITS) ?
                  ((VOLT_BITS > HYST_BITS) ? VOLT_BITS : HYST_BITS) :
                  ((TIMER_BITS > HYST_BITS) ? TIMER_BITS : HYST_BITS))-1:0] csr_wdata
);

   localparam int BandBits = ((VOLT_BITS > HYST_BITS) ? VOLT_BITS : HYST_BITS) + 2;

   logic [VOLT_BITS-1:0]  lower_ff,   upper_ff;
   logic [HYST_BITS-1:0]  hyst_ff;
   logic [TIMER_BITS-1:0] confirm_ff, recover_ff;

   logic                  in_valid_ff;
   logic [VOLT_BITS-1:0]  voltage_ff;
   logic                  charging_ff;
   logic                  out_valid_ff;
   result_type            out_ff;
   result_type            result;

   logic                  out_free;
   logic                  advance;
   logic                  take_req;

   logic [BandBits-1:0]        nlo_sum;
   logic [BandBits-1:0]        volt_max;
   logic signed [BandBits-1:0] sample_s;
   logic signed [BandBits-1:0] lower_s, upper_s, nlo_s, nhi_s;
   cls_type                    wide_cls, narrow_cls;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= VOLT_BITS'(LOWER_LIMIT_RST);
         upper_ff   <= VOLT_BITS'(UPPER_LIMIT_RST);
         hyst_ff    <= HYST_BITS'(HYSTERESIS_RST);
         confirm_ff <= TIMER_BITS'(CONFIRM_PERIODS_RST);
         recover_ff <= TIMER_BITS'(RECOVER_PERIODS_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOWER_LIMIT:     lower_ff   <= csr_wdata[VOLT_BITS-1:0];
            CSR_UPPER_LIMIT:     upper_ff   <= csr_wdata[VOLT_BITS-1:0];
            CSR_HYSTERESIS:      hyst_ff    <= csr_wdata[HYST_BITS-1:0];
            CSR_CONFIRM_PERIODS: confirm_ff <= csr_wdata[TIMER_BITS-1:0];
            CSR_RECOVER_PERIODS: recover_ff <= csr_wdata[TIMER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input stage moves on whenever the result register is free
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         voltage_ff  <= req_voltage;
         charging_ff <= req_charging;
      end
   end

   // Band edges: widen to signed so the narrowed upper edge may go negative
   assign sample_s = $signed({{(BandBits-VOLT_BITS){1'b0}}, voltage_ff});
   assign lower_s  = $signed({{(BandBits-VOLT_BITS){1'b0}}, lower_ff});
   assign upper_s  = $signed({{(BandBits-VOLT_BITS){1'b0}}, upper_ff});
   assign volt_max = {{(BandBits-VOLT_BITS){1'b0}}, {VOLT_BITS{1'b1}}};
   assign nlo_sum  = {{(BandBits-VOLT_BITS){1'b0}}, lower_ff}
                   + {{(BandBits-HYST_BITS){1'b0}}, hyst_ff};
   // Saturate the raised lower edge at the largest voltage
   assign nlo_s    = $signed((nlo_sum > volt_max) ? volt_max : nlo_sum);
   assign nhi_s    = upper_s - $signed({{(BandBits-HYST_BITS){1'b0}}, hyst_ff});

   svfm_classify #(
      .BAND_BITS (BandBits)
   ) u_wide (
      .sample  (sample_s),
      .band_lo (lower_s),
      .band_hi (upper_s),
      .cls     (wide_cls)
   );

   svfm_classify #(
      .BAND_BITS (BandBits)
   ) u_narrow (
      .sample  (sample_s),
      .band_lo (nlo_s),
      .band_hi (nhi_s),
      .cls     (narrow_cls)
   );

   svfm_fsm #(
      .TIMER_BITS (TIMER_BITS)
   ) u_fsm (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .charging        (charging_ff),
      .wide_cls        (wide_cls),
      .narrow_cls      (narrow_cls),
      .confirm_periods (confirm_ff),
      .recover_periods (recover_ff),
      .result          (result)
   );

   // Result register: load on advance, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_mode       = out_ff.mode;
   assign rsp_voltage_ok = out_ff.voltage_ok;
   assign rsp_alarm_low  = out_ff.alarm_low;
   assign rsp_alarm_high = out_ff.alarm_high;
   assign rsp_relay_cmd  = out_ff.relay_cmd;

endmodule

// ===== src/svfm_checker.sv =====
module svfm_checker
   import svfm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_mode,
   input logic       rsp_voltage_ok,
   input logic [1:0] rsp_relay_cmd
);

   // Reset empties the result register
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   // An empty result register never holds off the input side
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

   // A stalled result beat holds
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode) && $stable(rsp_relay_cmd))
      else $error("stalled result beat changed");

   // Opening the relay only comes with a fresh fault and the ok flag clear
   a_open_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relay_cmd == RELAY_OPEN |->
         !rsp_voltage_ok && (rsp_mode == MODE_LOW_FAULT || rsp_mode == MODE_HIGH_FAULT))
      else $error("relay open without a latched fault");

   // Reclosing the relay only comes with recovery to ok
   a_close_on_recover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relay_cmd == RELAY_CLOSE |-> rsp_voltage_ok && rsp_mode == MODE_OK)
      else $error("relay close without recovery");

endmodule

bind supply_voltage_fault_monitor svfm_checker u_svfm_checker (.*);

// ===== test/supply_voltage_fault_monitor_tb.sv =====
module supply_voltage_fault_monitor_tb
   import svfm_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 140;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD    = 400;
   localparam int VMAX         = 65535;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [15:0]               req_voltage;
   logic                      req_charging;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [2:0]                rsp_mode;
   logic                      rsp_voltage_ok;
   logic                      rsp_alarm_low;
   logic                      rsp_alarm_high;
   logic [1:0]                rsp_relay_cmd;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [15:0]               csr_wdata;

   // One row of the directed plan: a sample beat or a register write
   typedef struct {
      logic                      is_csr;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [15:0]               value;
      logic                      charging;
      logic                      typed;
      result_type                want;
   } plan_row_type;

   plan_row_type plan[$];
   result_type   status_due[$];

   // Shadow of the monitor's registers and state
   logic [15:0] cfg_lower;
   logic [15:0] cfg_upper;
   logic [11:0] cfg_hyst;
   logic [15:0] cfg_confirm;
   logic [15:0] cfg_recover;
   logic [2:0]  mon_mode;
   logic [15:0] mon_elapsed;
   logic        mon_ok;
   logic        mon_low;
   logic        mon_high;

   int fail_count    = 0;
   int cycle_count   = 0;
   int samples_sent  = 0;
   int beats_checked = 0;
   int latch_count   = 0;
   int recover_count = 0;
   int reg_writes    = 0;
   int phase_sent;
   int pause_at;
   logic sender_steady   = 1'b0;
   logic receiver_steady = 1'b0;
   logic hold_req        = 1'b0;
   int   hold_left       = 0;
   int   open_left       = 0;
   logic stall_next;
   result_type beat_got;
   result_type beat_want;
   logic beat_bad;

   supply_voltage_fault_monitor uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_voltage    (req_voltage),
      .req_charging   (req_charging),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mode       (rsp_mode),
      .rsp_voltage_ok (rsp_voltage_ok),
      .rsp_alarm_low  (rsp_alarm_low),
      .rsp_alarm_high (rsp_alarm_high),
      .rsp_relay_cmd  (rsp_relay_cmd),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("supply_voltage_fault_monitor_tb failed");
         $finish;
      end
   end

   // Gap length: mostly none, sometimes short, rarely long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic cls_type band_of(input int v, input int lo, input int hi);
      if (v >= lo && v <= hi) return CLS_IN;
      if (v > hi) return CLS_HIGH;
      return CLS_LOW;
   endfunction

   // Advance the shadow monitor by one sample and return the beat it should emit
   function automatic result_type next_status(input logic [15:0] volts,
                                              input logic charging);
      int          v;
      int          nlo;
      int          nhi;
      cls_type     wide;
      cls_type     narrow;
      logic [15:0] t;
      result_type  r;
      v   = int'(volts);
      nlo = int'(cfg_lower) + int'(cfg_hyst);
      if (nlo > VMAX) nlo = VMAX;
      nhi    = int'(cfg_upper) - int'(cfg_hyst);
      wide   = band_of(v, int'(cfg_lower), int'(cfg_upper));
      narrow = band_of(v, nlo, nhi);
      t      = (mon_elapsed == 16'hFFFF) ? 16'hFFFF : mon_elapsed + 16'd1;
      r.relay_cmd = RELAY_NONE;
      case (mon_mode)
         MODE_LOW_PEND, MODE_HIGH_PEND: begin
            if (t >= cfg_confirm) begin
               // Excursion confirmed: latch the fault
               mon_elapsed = t;
               mon_ok      = 1'b0;
               if (charging) r.relay_cmd = RELAY_OPEN;
               mon_mode = (mon_mode == MODE_LOW_PEND) ? MODE_LOW_FAULT : MODE_HIGH_FAULT;
               latch_count++;
            end else if (wide == CLS_IN) begin
               mon_elapsed = '0;
               mon_mode    = MODE_OK;
            end else if (wide == CLS_LOW && mon_mode == MODE_HIGH_PEND) begin
               mon_elapsed = '0;
               mon_mode    = MODE_LOW_PEND;
            end else if (wide == CLS_HIGH && mon_mode == MODE_LOW_PEND) begin
               mon_elapsed = '0;
               mon_mode    = MODE_HIGH_PEND;
            end else begin
               mon_elapsed = t;
            end
         end
         MODE_LOW_FAULT, MODE_HIGH_FAULT: begin
            if (narrow == CLS_IN) begin
               mon_elapsed = '0;
               mon_mode    = MODE_RECOVER;
            end else if (narrow == CLS_LOW) begin
               mon_low  = 1'b1;
               mon_high = 1'b0;
            end else begin
               mon_high = 1'b1;
               mon_low  = 1'b0;
            end
         end
         MODE_RECOVER: begin
            mon_elapsed = t;
            if (t >= cfg_recover) begin
               mon_ok = 1'b1;
               if (charging) r.relay_cmd = RELAY_CLOSE;
               mon_mode = MODE_OK;
               recover_count++;
            end else if (narrow == CLS_LOW) begin
               mon_mode = MODE_LOW_FAULT;
            end else if (narrow == CLS_HIGH) begin
               mon_mode = MODE_HIGH_FAULT;
            end
         end
         default: begin
            mon_low  = 1'b0;
            mon_high = 1'b0;
            mon_mode = MODE_OK;
            if (wide == CLS_IN) begin
               mon_ok = 1'b1;
            end else begin
               mon_elapsed = '0;
               mon_mode    = (wide == CLS_LOW) ? MODE_LOW_PEND : MODE_HIGH_PEND;
            end
         end
      endcase
      r.mode       = mon_mode;
      r.voltage_ok = mon_ok;
      r.alarm_low  = mon_low;
      r.alarm_high = mon_high;
      return r;
   endfunction

   // Voltage drawn from a region of the current bands
   function automatic logic [15:0] pick_volts(input int kind);
      int lo;
      int hi;
      int nlo;
      int nhi;
      int e;
      lo  = int'(cfg_lower);
      hi  = int'(cfg_upper);
      nlo = lo + int'(cfg_hyst);
      if (nlo > VMAX) nlo = VMAX;
      nhi = hi - int'(cfg_hyst);
      case (kind)
         0: e = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(VMAX, 0);
         1: e = (lo > 0) ? $urandom_range(lo - 1, 0) : 0;
         2: e = (hi < VMAX) ? $urandom_range(VMAX, hi + 1) : VMAX;
         3: e = (nlo <= nhi) ? $urandom_range(nhi, nlo) : $urandom_range(VMAX, 0);
         4: begin
            case ($urandom_range(0, 7))
               0: e = lo - 1;
               1: e = lo;
               2: e = hi;
               3: e = hi + 1;
               4: e = nlo - 1;
               5: e = nlo;
               6: e = nhi;
               default: e = nhi + 1;
            endcase
            if (e < 0) e = 0;
            if (e > VMAX) e = VMAX;
         end
         default: e = $urandom_range(VMAX, 0);
      endcase
      return e[15:0];
   endfunction

   // Offer one sample beat, wait for it to be taken and queue its expected status
   task automatic send_sample(input logic [15:0] volts, input logic charging,
                              input logic typed, input result_type want);
      int         gap;
      result_type due;
      gap = sender_steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_voltage  <= volts;
      req_charging <= charging;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = next_status(volts, charging);
      status_due.push_back(typed ? want : due);
      samples_sent++;
   endtask

   // Drop valid and let every outstanding beat drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LOWER_LIMIT:     cfg_lower   = val;
         CSR_UPPER_LIMIT:     cfg_upper   = val;
         CSR_HYSTERESIS:      cfg_hyst    = val[11:0];
         CSR_CONFIRM_PERIODS: cfg_confirm = val;
         CSR_RECOVER_PERIODS: cfg_recover = val;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic plan_sample(input logic [15:0] v, input logic c);
      plan_row_type r;
      r.is_csr   = 1'b0;
      r.csr_idx  = CSR_LOWER_LIMIT;
      r.value    = v;
      r.charging = c;
      r.typed    = 1'b0;
      r.want     = '0;
      plan.push_back(r);
   endtask

   task automatic plan_check(input logic [15:0] v, input logic c, input logic [2:0] m,
                             input logic ok, input logic lo, input logic hi,
                             input logic [1:0] relay);
      plan_row_type r;
      r.is_csr          = 1'b0;
      r.csr_idx         = CSR_LOWER_LIMIT;
      r.value           = v;
      r.charging        = c;
      r.typed           = 1'b1;
      r.want.mode       = m;
      r.want.voltage_ok = ok;
      r.want.alarm_low  = lo;
      r.want.alarm_high = hi;
      r.want.relay_cmd  = relay;
      plan.push_back(r);
   endtask

   task automatic plan_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] val);
      plan_row_type r;
      r.is_csr   = 1'b1;
      r.csr_idx  = idx;
      r.value    = val;
      r.charging = 1'b0;
      r.typed    = 1'b0;
      r.want     = '0;
      plan.push_back(r);
   endtask

   // Send up to len beats of one voltage region, within the phase quota
   task automatic send_run(input int kind, input int len);
      repeat (len) begin
         if (phase_sent < PHASE_ITEMS) begin
            send_sample(pick_volts(kind), ($urandom_range(0, 9) < 7), 1'b0, '0);
            phase_sent++;
            if (phase_sent == pause_at) wait_idle();
         end
      end
   endtask

   // Choose a register setting for one phase (fixed in phases 0 and 5, random otherwise) and load it
   task automatic load_phase_settings(input int phase);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] hy;
      logic [15:0] cf;
      logic [15:0] rc;
      if (phase == 0) begin
         lo = 16'd0; hi = 16'hFFFF; hy = 16'd0; cf = 16'hFFFF; rc = 16'd0;
      end else if (phase == 5) begin
         lo = 16'hFFFF; hi = 16'd0; hy = 16'd4095; cf = 16'd0; rc = 16'd0;
      end else begin
         lo = 16'($urandom_range(3000, 500));
         hi = lo + 16'($urandom_range(1500, 0));
         hy = 16'($urandom_range(400, 0));
         cf = 16'($urandom_range(5, 0));
         rc = 16'($urandom_range(5, 0));
         // Now and then push a single register to an extreme, or raise the lower edge above the upper
         case ($urandom_range(0, 11))
            0: lo = 16'd0;
            1: hi = 16'hFFFF;
            2: hy = 16'd4095;
            3: cf = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd40;
            4: rc = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd40;
            5: begin lo = hi + 16'd200; end
            default: ;
         endcase
      end
      set_reg(CSR_LOWER_LIMIT, lo);
      set_reg(CSR_UPPER_LIMIT, hi);
      set_reg(CSR_HYSTERESIS, hy);
      set_reg(CSR_CONFIRM_PERIODS, cf);
      set_reg(CSR_RECOVER_PERIODS, rc);
   endtask

   // Result side: check each beat taken, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beat_got.mode       = rsp_mode;
         beat_got.voltage_ok = rsp_voltage_ok;
         beat_got.alarm_low  = rsp_alarm_low;
         beat_got.alarm_high = rsp_alarm_high;
         beat_got.relay_cmd  = rsp_relay_cmd;
         if (status_due.size() == 0) begin
            $error("status beat with nothing outstanding: mode %0d", rsp_mode);
            fail_count++;
         end else begin
            beat_want = status_due.pop_front();
            beat_bad  = 1'b0;
            if (beat_got.mode !== beat_want.mode) begin
               $error("mode: expected %0d, got %0d", beat_want.mode, beat_got.mode);
               beat_bad = 1'b1;
            end
            if (beat_got.voltage_ok !== beat_want.voltage_ok) begin
               $error("voltage_ok: expected %0d, got %0d",
                      beat_want.voltage_ok, beat_got.voltage_ok);
               beat_bad = 1'b1;
            end
            if (beat_got.alarm_low !== beat_want.alarm_low) begin
               $error("alarm_low: expected %0d, got %0d",
                      beat_want.alarm_low, beat_got.alarm_low);
               beat_bad = 1'b1;
            end
            if (beat_got.alarm_high !== beat_want.alarm_high) begin
               $error("alarm_high: expected %0d, got %0d",
                      beat_want.alarm_high, beat_got.alarm_high);
               beat_bad = 1'b1;
            end
            if (beat_got.relay_cmd !== beat_want.relay_cmd) begin
               $error("relay_cmd: expected %0d, got %0d",
                      beat_want.relay_cmd, beat_got.relay_cmd);
               beat_bad = 1'b1;
            end
            if (beat_bad) fail_count++;
            beats_checked++;
         end
      end
      // A long hold-off, when asked for, overrides the normal pattern
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req  = 1'b0;
      end
      if (hold_left == 0 && open_left == 0 && !receiver_steady) begin
         hold_left = idle_len();
         open_left = $urandom_range(10, 1);
      end
      if (hold_left > 0) begin
         stall_next = 1'b1;
         hold_left--;
      end else begin
         stall_next = 1'b0;
         if (open_left > 0) open_left--;
      end
      rsp_stall <= stall_next;
   end

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_voltage  <= '0;
      req_charging <= 1'b0;
      rsp_stall    <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_LOWER_LIMIT;
      csr_wdata    <= '0;
      cfg_lower    = 16'(LOWER_LIMIT_RST);
      cfg_upper    = 16'(UPPER_LIMIT_RST);
      cfg_hyst     = 12'(HYSTERESIS_RST);
      cfg_confirm  = 16'(CONFIRM_PERIODS_RST);
      cfg_recover  = 16'(RECOVER_PERIODS_RST);
      mon_mode     = MODE_OK;
      mon_elapsed  = '0;
      mon_ok       = 1'b0;
      mon_low      = 1'b0;
      mon_high     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Register reset values: band edges, direction swap, early return to ok
      plan_check(16'd2000, 1'b0, MODE_OK, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_check(16'hFFFF, 1'b1, MODE_HIGH_PEND, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_sample(16'd0, 1'b0);
      plan_check(16'd1760, 1'b1, MODE_OK, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_check(16'd2640, 1'b0, MODE_OK, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_check(16'd2641, 1'b0, MODE_HIGH_PEND, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      // Short timers: latch, alarms in fault, recovery with relay close
      plan_reg(CSR_CONFIRM_PERIODS, 16'd1);
      plan_reg(CSR_RECOVER_PERIODS, 16'd2);
      plan_check(16'd2641, 1'b1, MODE_HIGH_FAULT, 1'b0, 1'b0, 1'b0, RELAY_OPEN);
      plan_check(16'd1000, 1'b0, MODE_HIGH_FAULT, 1'b0, 1'b1, 1'b0, RELAY_NONE);
      plan_check(16'd3000, 1'b0, MODE_HIGH_FAULT, 1'b0, 1'b0, 1'b1, RELAY_NONE);
      plan_check(16'd2000, 1'b1, MODE_RECOVER, 1'b0, 1'b0, 1'b1, RELAY_NONE);
      plan_check(16'd2000, 1'b0, MODE_RECOVER, 1'b0, 1'b0, 1'b1, RELAY_NONE);
      plan_check(16'd2000, 1'b1, MODE_OK, 1'b1, 1'b0, 1'b1, RELAY_CLOSE);
      plan_check(16'd2000, 1'b0, MODE_OK, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_check(16'd0, 1'b1, MODE_LOW_PEND, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_check(16'd0, 1'b0, MODE_LOW_FAULT, 1'b0, 1'b0, 1'b0, RELAY_NONE);
      plan_check(16'd1800, 1'b0, MODE_LOW_FAULT, 1'b0, 1'b1, 1'b0, RELAY_NONE);
      plan_check(16'd2540, 1'b0, MODE_RECOVER, 1'b0, 1'b1, 1'b0, RELAY_NONE);
      plan_sample(16'd2541, 1'b0);
      // Saturated lower edge and negative upper edge: everything is high
      plan_reg(CSR_HYSTERESIS, 16'd4095);
      plan_reg(CSR_LOWER_LIMIT, 16'd65000);
      plan_reg(CSR_UPPER_LIMIT, 16'd100);
      plan_check(16'hFFFF, 1'b1, MODE_HIGH_FAULT, 1'b0, 1'b0, 1'b1, RELAY_NONE);
      // Zero periods over the full range
      plan_reg(CSR_LOWER_LIMIT, 16'd0);
      plan_reg(CSR_UPPER_LIMIT, 16'hFFFF);
      plan_reg(CSR_HYSTERESIS, 16'd0);
      plan_reg(CSR_CONFIRM_PERIODS, 16'd0);
      plan_reg(CSR_RECOVER_PERIODS, 16'd0);
      plan_check(16'd0, 1'b1, MODE_RECOVER, 1'b0, 1'b0, 1'b1, RELAY_NONE);
      plan_check(16'd0, 1'b1, MODE_OK, 1'b1, 1'b0, 1'b1, RELAY_CLOSE);
      plan_check(16'hFFFF, 1'b0, MODE_OK, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      // Inverted band: above the upper edge is high, anything else low
      plan_reg(CSR_LOWER_LIMIT, 16'd3000);
      plan_reg(CSR_UPPER_LIMIT, 16'd2000);
      plan_check(16'd2500, 1'b1, MODE_HIGH_PEND, 1'b1, 1'b0, 1'b0, RELAY_NONE);
      plan_sample(16'd1500, 1'b1);
      plan_check(16'd1500, 1'b0, MODE_HIGH_FAULT, 1'b0, 1'b1, 1'b0, RELAY_NONE);

      // Walk the directed plan
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            wait_idle();
            set_reg(plan[i].csr_idx, plan[i].value);
         end else begin
            send_sample(plan[i].value, plan[i].charging, plan[i].typed, plan[i].want);
         end
      end

      // Random phases: excursion, optional swap, recovery, settle; plus noise
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         load_phase_settings(phase);
         sender_steady   = (phase == 2 || phase == 4 || phase == 8);
         receiver_steady = (phase == 2 || phase == 7);
         pause_at        = (phase == 6) ? PHASE_ITEMS / 2 : -1;
         if (phase == 4) hold_req = 1'b1;
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_run(($urandom_range(0, 1) != 0) ? 4 : 5, 1);
            end else begin
               send_run($urandom_range(2, 1),
                        $urandom_range((cfg_confirm > 8 ? 8 : int'(cfg_confirm)) + 2, 1));
               if ($urandom_range(0, 3) == 0)
                  send_run($urandom_range(2, 1), $urandom_range(4, 1));
               send_run(3, $urandom_range((cfg_recover > 8 ? 8 : int'(cfg_recover)) + 2, 1));
               send_run(0, $urandom_range(4, 1));
            end
         end
      end

      wait_idle();
      $display("covered %0d samples and %0d register writes; %0d status beats checked",
               samples_sent, reg_writes, beats_checked);
      $display("predicted %0d fault latches and %0d recoveries", latch_count, recover_count);
      if (fail_count == 0) begin
         $display("supply_voltage_fault_monitor_tb passed");
      end else begin
         $display("supply_voltage_fault_monitor_tb failed");
      end
      $finish;
   end

endmodule
